// File: design/uws_pkg.sv
// Shared types, constants and helper functions for the UTF-8 whitespace word splitter.
package uws_pkg;

   localparam int PositionBitsDefault = 32;

   localparam logic [15:0] MaxLenReset = 16'hFFFF;
   localparam logic [16:0] LenCap      = 17'h10000;

   // Values of the request kind flag.
   localparam logic FuncData = 1'b0;
   localparam logic FuncEnd  = 1'b1;

   // What the decoder hands to the word tracker for one request.
   typedef struct packed {
      logic       eos;          // end of stream marker
      logic [1:0] flush_count;  // pending bytes that join the word as error runes
      logic       rune;         // a rune is complete in this request
      logic       rune_space;   // that rune is whitespace
      logic [2:0] rune_len;     // its length in bytes
      logic [1:0] rune_back;    // its start, counted back from the current offset
   } uws_event_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] start;
      logic [15:0] length;
      logic        too_long;
   } uws_result_type;

   function automatic logic space_rune(input logic [20:0] cp);
      return cp inside {[21'h000009 : 21'h00000D], 21'h000020, 21'h000085, 21'h0000A0,
                        21'h001680, [21'h002000 : 21'h00200A], 21'h002028, 21'h002029,
                        21'h00202F, 21'h00205F, 21'h003000};
   endfunction

   function automatic logic [16:0] sat_len(input logic [16:0] v);
      return (v > LenCap) ? LenCap : v;
   endfunction

endpackage

// File: design/uws_utf8.sv
// Strict UTF-8 decoder: holds the unfinished sequence and classifies each completed rune.
module uws_utf8
   import uws_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          func,
   input  logic [7:0]    byte_value,
   output uws_event_type ev
);

   localparam logic [7:0] LeadE0 = 8'hE0;
   localparam logic [7:0] LeadED = 8'hED;
   localparam logic [7:0] LeadF0 = 8'hF0;
   localparam logic [7:0] LeadF4 = 8'hF4;

   logic [23:0] pend_bytes_ff, pend_bytes_in;
   logic [1:0]  pend_count_ff, pend_count_in;
   logic [2:0]  exp_len_ff, exp_len_in;

   logic [7:0]  lo, hi;
   logic        cont_ok, completes;
   logic [20:0] cp;

   always_comb begin
      lo = 8'h80;
      hi = 8'hBF;
      if (pend_count_ff == 2'd1) begin
         case (pend_bytes_ff[7:0])
            LeadE0:  lo = 8'hA0;
            LeadED:  hi = 8'h9F;
            LeadF0:  lo = 8'h90;
            LeadF4:  hi = 8'h8F;
            default: ;
         endcase
      end
      cont_ok   = (pend_count_ff != 2'd0) && (byte_value >= lo) && (byte_value <= hi);
      completes = cont_ok && (({1'b0, pend_count_ff} + 3'd1) == exp_len_ff);

      case (exp_len_ff)
         3'd2: cp = {10'd0, pend_bytes_ff[4:0], byte_value[5:0]};
         3'd3: cp = {5'd0, pend_bytes_ff[11:8], pend_bytes_ff[5:0], byte_value[5:0]};
         3'd4: cp = {pend_bytes_ff[18:16], pend_bytes_ff[13:8], pend_bytes_ff[5:0],
                     byte_value[5:0]};
         default: cp = 21'd0;
      endcase
   end

   always_comb begin
      ev            = '0;
      pend_bytes_in = pend_bytes_ff;
      pend_count_in = pend_count_ff;
      exp_len_in    = exp_len_ff;

      if (func == FuncEnd) begin
         ev.eos         = 1'b1;
         ev.flush_count = pend_count_ff;
         pend_bytes_in  = '0;
         pend_count_in  = '0;
         exp_len_in     = '0;
      end else if (cont_ok) begin
         if (completes) begin
            ev.rune       = 1'b1;
            ev.rune_space = space_rune(cp);
            ev.rune_len   = exp_len_ff;
            ev.rune_back  = pend_count_ff;
            pend_bytes_in = '0;
            pend_count_in = '0;
            exp_len_in    = '0;
         end else begin
            pend_bytes_in = {pend_bytes_ff[15:0], byte_value};
            pend_count_in = pend_count_ff + 2'd1;
         end
      end else begin
         // Any pending bytes were broken by this one; they become error runes.
         ev.flush_count = pend_count_ff;
         pend_bytes_in  = '0;
         pend_count_in  = '0;
         exp_len_in     = '0;
         if (byte_value < 8'h80) begin
            ev.rune       = 1'b1;
            ev.rune_space = space_rune({13'd0, byte_value});
            ev.rune_len   = 3'd1;
         end else if (byte_value inside {[8'hC2 : 8'hF4]}) begin
            pend_bytes_in = {16'd0, byte_value};
            pend_count_in = 2'd1;
            if (byte_value <= 8'hDF) begin
               exp_len_in = 3'd2;
            end else if (byte_value <= 8'hEF) begin
               exp_len_in = 3'd3;
            end else begin
               exp_len_in = 3'd4;
            end
         end else begin
            ev.rune     = 1'b1;
            ev.rune_len = 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bytes_ff <= '0;
         pend_count_ff <= '0;
         exp_len_ff    <= '0;
      end else if (step) begin
         pend_bytes_ff <= pend_bytes_in;
         pend_count_ff <= pend_count_in;
         exp_len_ff    <= exp_len_in;
      end
   end

endmodule

// File: design/uws_word.sv
// Word tracker: stream offset, open word state and the word report.
module uws_word
   import uws_pkg::*;
#(
   parameter int PositionBits = PositionBitsDefault
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  uws_event_type  ev,
   input  logic [15:0]    max_len,
   output uws_result_type res
);

   logic [PositionBits-1:0] pos_ff, pos_in;
   logic                    in_word_ff, in_word_in;
   logic [PositionBits-1:0] start_ff, start_in;
   logic [16:0]             len_ff, len_in;

   logic                    in1;
   logic [PositionBits-1:0] start1;
   logic [16:0]             len1;
   logic [63:0]             start_wide;

   always_comb begin
      // Pending bytes that were flushed come first.
      in1    = in_word_ff || (ev.flush_count != 2'd0);
      start1 = in_word_ff ? start_ff : pos_ff - PositionBits'(ev.flush_count);
      len1   = in_word_ff ? sat_len(len_ff + 17'(ev.flush_count)) : 17'(ev.flush_count);

      start_wide   = 64'(start1);
      res.valid    = step && in1 && (ev.eos || (ev.rune && ev.rune_space));
      res.start    = start_wide[31:0];
      res.too_long = len1 > {1'b0, max_len};
      res.length   = res.too_long ? max_len : len1[15:0];

      pos_in     = pos_ff + PositionBits'(1);
      in_word_in = in1;
      start_in   = start1;
      len_in     = len1;
      if (ev.eos) begin
         pos_in     = '0;
         in_word_in = 1'b0;
         start_in   = '0;
         len_in     = '0;
      end else if (ev.rune && ev.rune_space) begin
         in_word_in = 1'b0;
         len_in     = '0;
      end else if (ev.rune) begin
         in_word_in = 1'b1;
         if (in1) begin
            len_in = sat_len(len1 + 17'(ev.rune_len));
         end else begin
            start_in = pos_ff - PositionBits'(ev.rune_back);
            len_in   = 17'(ev.rune_len);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         in_word_ff <= 1'b0;
         start_ff   <= '0;
         len_ff     <= '0;
      end else if (step) begin
         pos_ff     <= pos_in;
         in_word_ff <= in_word_in;
         start_ff   <= start_in;
         len_ff     <= len_in;
      end
   end

endmodule

// File: design/utf8_whitespace_word_splitter.sv
// Top level of the UTF-8 whitespace word splitter.
// This block reads a byte stream, one request per byte, decodes it as strict UTF-8 and
// reports every word that lies between whitespace runes as its start offset and its length
// in bytes. It sustains one request per clock while no result is held up. A request is held
// in the input register, where the decode and word tracking logic works on it and updates
// its state once per byte. The result register is loaded as the request closing a word
// leaves the input register, and the word is offered from there until it is taken. The rate
// is set by that per-request state update. The output register lets the next request
// be taken while a result still waits, and the input stage only stalls while a result is
// held up. A request with tuser set marks the end of the stream: any open word is reported
// and the byte offset starts again from zero. The user must write the maximum word length
// register through the csr port only while the block is idle; the block itself does not
// enforce this. Longer words report that maximum with too_long set.
module utf8_whitespace_word_splitter
   import uws_pkg::*;
#(
   parameter int POSITION_BITS = PositionBitsDefault
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic [0:0]  req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] word_start, [47:32] word_length
   output logic [0:0]  rsp_tuser,   // [0] too_long
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata
);

   logic           in_valid_ff;
   logic           func_ff;
   logic [7:0]     byte_ff;
   logic           advance;
   logic [15:0]    max_len_ff;
   uws_event_type  ev;
   uws_result_type res;
   logic           out_valid_ff, out_valid_in;
   logic [47:0]    out_data_ff;
   logic           out_flag_ff;

   // The held request moves on whenever the output register is free or being emptied.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         func_ff <= req_tuser[0];
         byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxLenReset;
      end else if (csr_wen) begin
         max_len_ff <= csr_wdata;
      end
   end

   uws_utf8 u_utf8 (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .func       (func_ff),
      .byte_value (byte_ff),
      .ev         (ev)
   );

   uws_word #(
      .PositionBits (POSITION_BITS)
   ) u_word (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .ev      (ev),
      .max_len (max_len_ff),
      .res     (res)
   );

   // Output register: loaded when a word closes, cleared once the result is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (res.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         out_data_ff <= {res.length, res.start};
         out_flag_ff <= res.too_long;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_flag_ff;

endmodule

// File: design/uws_checker.sv
// Port-level checker for the UTF-8 whitespace word splitter, bound to the top level.
module uws_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before it was taken");

   // A fresh result always follows an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result appeared without a matching request");

   // A word holds at least one byte, so an unsaturated length is never zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[47:32] != 16'd0)
      else $error("empty word reported");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

endmodule

bind utf8_whitespace_word_splitter uws_checker u_checker (.*);
